// ===== rtl/frlb_pkg.sv =====
// Shared types and constants of the least-loaded FASTA record binner.
// Used by every module of the block; depends on nothing.
`default_nettype none

package frlb_pkg;

  // Bin store geometry.
  localparam int MAX_BINS = 16;
  localparam int LOAD_W   = 40;
  localparam int BIN_W    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int CNT_W    = $clog2(MAX_BINS + 1);
  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

  // Field widths.
  localparam int DATA_W      = 8;
  localparam int LEN_W       = 32;
  localparam int IDX_FIELD_W = 4;
  localparam int CFG_W       = 5;
  localparam int OUT_TDATA_W = 40;

  // Byte codes the line framer reacts to.
  localparam logic [DATA_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] BYTE_GT    = 8'h3E;
  localparam logic [DATA_W-1:0] BYTE_SPACE = 8'h20;

  // Command queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // One closed record waiting for a bin.
  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             last;
  } cmd_t;

  // Up to two closed records produced by one input word.
  typedef struct packed {
    logic [1:0] cnt;
    cmd_t       first;
    cmd_t       second;
  } push_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_EMIT
  } bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/fasta_record_least_loaded_binner.sv =====
// Least-loaded FASTA record binner.
//
// in_*  : one text byte per word, tdata[7:0] the byte, tlast marks the last
//         byte of the file (the open line and record are then flushed).
// out_* : one word per closed record, tdata[3:0] the chosen bin,
//         tdata[35:4] the record length, tdata[39:36] zero; tlast marks the
//         last record closed by a given input byte.
// cfg_* : write of the bin count; cfg_ready is always high. Write only while
//         the block is idle.
// A byte is taken each cycle while the record queue (four entries) has room
// for two more records; most bytes close nothing and flow at full rate.
// Each closed record is placed by the bin picker's one-bin-per-cycle scan of
// the load store over the bins in use, and the result word is registered.
// Reset clears all bin loads, the line and record state and the queue, and
// sets the bin count to one. A stalled receiver holds the result word; the
// picker then waits, the queue fills and in_tready drops.
// Depends on frlb_pkg, frlb_front, frlb_queue and frlb_back.
`default_nettype none

module fasta_record_least_loaded_binner (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // data_byte
  input  wire logic                              in_tlast,   // final_byte
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [frlb_pkg::OUT_TDATA_W-1:0]       out_tdata,  // bin_index, record_length
  output logic                                   out_tlast,  // last_result
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [frlb_pkg::CFG_W-1:0]        cfg_data    // bin_count
);

  logic [frlb_pkg::CFG_W-1:0] bin_count_r;
  frlb_pkg::push_t            push;
  frlb_pkg::cmd_t             head;
  logic                       q_room;
  logic                       head_valid;
  logic                       pop;

  // Bin count register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_count_r <= frlb_pkg::CFG_W'(1);
    end else if (cfg_valid) begin
      bin_count_r <= cfg_data;
    end
  end

  frlb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_room    (q_room),
    .push      (push)
  );

  frlb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (q_room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  frlb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bin_count  (bin_count_r),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== rtl/frlb_front.sv =====
// Front end: frames the byte stream into lines and closes records.
// Depends on frlb_pkg; feeds closed records to frlb_queue.
`default_nettype none

module frlb_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [frlb_pkg::DATA_W-1:0]   in_tdata,
  input  wire logic                          in_tlast,
  input  wire logic                          q_room,
  output frlb_pkg::push_t                    push
);

  logic                         rec_open_r, rec_open_nxt;
  logic [frlb_pkg::LEN_W-1:0]   open_len_r, open_len_nxt;
  logic                         line_marker_r, line_marker_nxt;
  logic                         line_nonempty_r, line_nonempty_nxt;
  logic [frlb_pkg::LEN_W-1:0]   line_cnt_r, line_cnt_nxt;

  logic                         accept;
  logic                         is_lf;
  logic                         marker_upd, nonempty_upd;
  logic                         count_byte;
  logic [frlb_pkg::LEN_W-1:0]   cnt_upd;
  logic                         line_end;
  logic [frlb_pkg::LEN_W+1:0]   len_sum;
  logic [frlb_pkg::LEN_W-1:0]   len_grown;
  logic                         close_a, close_b;
  logic                         open_mid;
  logic [frlb_pkg::LEN_W-1:0]   len_mid;

  assign in_tready = q_room;
  assign accept    = in_tvalid && q_room;

  // Line state including the current word.
  always_comb begin
    is_lf        = (in_tdata == frlb_pkg::BYTE_LF);
    marker_upd   = line_marker_r || (!is_lf && (in_tdata == frlb_pkg::BYTE_GT));
    nonempty_upd = line_nonempty_r || !is_lf;
    count_byte   = !is_lf && (in_tdata != frlb_pkg::BYTE_SPACE);
    cnt_upd      = (count_byte && (line_cnt_r != '1)) ? line_cnt_r + 1'b1 : line_cnt_r;
    line_end     = is_lf || in_tlast;
    // Open length plus the line's count, in one saturating add.
    len_sum      = {2'b00, open_len_r} + {2'b00, line_cnt_r} +
                   {{(frlb_pkg::LEN_W+1){1'b0}}, count_byte};
    len_grown    = (len_sum[frlb_pkg::LEN_W+1:frlb_pkg::LEN_W] != 2'b00) ?
                   '1 : len_sum[frlb_pkg::LEN_W-1:0];
  end

  // Acting on the end of a line, then on the final flush.
  always_comb begin
    close_a  = 1'b0;
    open_mid = rec_open_r;
    len_mid  = open_len_r;
    if (line_end) begin
      if (marker_upd) begin
        close_a  = rec_open_r;
        open_mid = 1'b1;
        len_mid  = '0;
      end else if (!nonempty_upd) begin
        close_a  = rec_open_r;
        open_mid = 1'b0;
        len_mid  = '0;
      end else if (rec_open_r) begin
        len_mid  = len_grown;
      end
    end
    close_b = in_tlast && open_mid;

    push = '0;
    if (accept) begin
      if (close_a) begin
        push.first.length  = open_len_r;
        push.first.last    = !close_b;
        push.second.length = len_mid;
        push.second.last   = 1'b1;
        push.cnt           = close_b ? 2'd2 : 2'd1;
      end else if (close_b) begin
        push.first.length  = len_mid;
        push.first.last    = 1'b1;
        push.cnt           = 2'd1;
      end
    end

    rec_open_nxt      = rec_open_r;
    open_len_nxt      = open_len_r;
    line_marker_nxt   = line_marker_r;
    line_nonempty_nxt = line_nonempty_r;
    line_cnt_nxt      = line_cnt_r;
    if (accept) begin
      rec_open_nxt = in_tlast ? 1'b0 : open_mid;
      open_len_nxt = in_tlast ? '0 : len_mid;
      if (line_end) begin
        line_marker_nxt   = 1'b0;
        line_nonempty_nxt = 1'b0;
        line_cnt_nxt      = '0;
      end else begin
        line_marker_nxt   = marker_upd;
        line_nonempty_nxt = nonempty_upd;
        line_cnt_nxt      = cnt_upd;
      end
    end
  end

  // Record and line state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_open_r      <= 1'b0;
      open_len_r      <= '0;
      line_marker_r   <= 1'b0;
      line_nonempty_r <= 1'b0;
      line_cnt_r      <= '0;
    end else begin
      rec_open_r      <= rec_open_nxt;
      open_len_r      <= open_len_nxt;
      line_marker_r   <= line_marker_nxt;
      line_nonempty_r <= line_nonempty_nxt;
      line_cnt_r      <= line_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frlb_queue.sv =====
// Short queue of closed records between the front end and the bin picker.
// Takes up to two records a cycle and gives one. Depends on frlb_pkg.
`default_nettype none

module frlb_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire frlb_pkg::push_t push,
  output logic                 room,
  output logic                 head_valid,
  output frlb_pkg::cmd_t       head,
  input  wire logic            pop
);

  frlb_pkg::cmd_t             mem_r [frlb_pkg::Q_DEPTH];
  logic [frlb_pkg::Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [frlb_pkg::Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [frlb_pkg::Q_CW-1:0]  cnt_r, cnt_nxt;
  logic [frlb_pkg::Q_AW-1:0]  wr_ptr_inc;

  // Room for a word that closes two records at once.
  assign room       = (cnt_r <= frlb_pkg::Q_CW'(frlb_pkg::Q_DEPTH - 2));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];
  assign wr_ptr_inc = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + frlb_pkg::Q_AW'(push.cnt);
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + frlb_pkg::Q_CW'(push.cnt) - frlb_pkg::Q_CW'(pop);
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_ptr_inc] <= push.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frlb_back.sv =====
// Back end: scans the bin loads for the least loaded bin, one bin a cycle,
// updates its load and registers the result word. Depends on frlb_pkg.
`default_nettype none

module frlb_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic [frlb_pkg::CFG_W-1:0]        bin_count,
  input  wire logic                              head_valid,
  input  wire frlb_pkg::cmd_t                    head,
  output logic                                   pop,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [frlb_pkg::OUT_TDATA_W-1:0]       out_tdata,
  output logic                                   out_tlast
);

  localparam int SUM_W = ((frlb_pkg::LOAD_W > frlb_pkg::LEN_W) ?
                          frlb_pkg::LOAD_W : frlb_pkg::LEN_W) + 1;

  frlb_pkg::bk_state_t            state_r, state_nxt;
  logic [frlb_pkg::LOAD_W-1:0]    loads_r [frlb_pkg::MAX_BINS];
  logic [frlb_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [frlb_pkg::BIN_W-1:0]     best_idx_r, best_idx_nxt;
  logic [frlb_pkg::LOAD_W-1:0]    best_load_r, best_load_nxt;
  logic [frlb_pkg::CNT_W-1:0]     used;
  logic [frlb_pkg::LOAD_W-1:0]    rd_load;
  logic [SUM_W-1:0]               load_sum;
  logic [frlb_pkg::LOAD_W-1:0]    new_load;
  logic                           emit;
  logic                           out_valid_r;
  logic [frlb_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                           out_last_r;

  // Bins in use, with zero and oversize counts clamped.
  always_comb begin
    if (bin_count == '0) begin
      used = frlb_pkg::CNT_W'(1);
    end else if (32'(bin_count) > frlb_pkg::MAX_BINS) begin
      used = frlb_pkg::CNT_W'(frlb_pkg::MAX_BINS);
    end else begin
      used = frlb_pkg::CNT_W'(bin_count);
    end
  end

  assign rd_load  = loads_r[idx_r[frlb_pkg::BIN_W-1:0]];
  assign load_sum = SUM_W'(best_load_r) + SUM_W'(head.length);
  assign new_load = (load_sum > SUM_W'(frlb_pkg::LOAD_MAX)) ?
                    frlb_pkg::LOAD_MAX : frlb_pkg::LOAD_W'(load_sum);

  // Scan sequencer.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    best_idx_nxt  = best_idx_r;
    best_load_nxt = best_load_r;
    emit          = 1'b0;
    unique case (state_r)
      frlb_pkg::BK_IDLE: begin
        if (head_valid) begin
          idx_nxt       = frlb_pkg::CNT_W'(1);
          best_idx_nxt  = '0;
          best_load_nxt = loads_r[0];
          state_nxt     = frlb_pkg::BK_SCAN;
        end
      end
      frlb_pkg::BK_SCAN: begin
        if (idx_r < used) begin
          if (rd_load < best_load_r) begin
            best_idx_nxt  = idx_r[frlb_pkg::BIN_W-1:0];
            best_load_nxt = rd_load;
          end
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = frlb_pkg::BK_EMIT;
        end
      end
      frlb_pkg::BK_EMIT: begin
        if (!out_valid_r || out_tready) begin
          emit      = 1'b1;
          state_nxt = frlb_pkg::BK_IDLE;
        end
      end
      default: state_nxt = frlb_pkg::BK_IDLE;
    endcase
  end

  assign pop = emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= frlb_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    best_idx_r  <= best_idx_nxt;
    best_load_r <= best_load_nxt;
  end

  // Bin loads, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < frlb_pkg::MAX_BINS; i++) begin
        loads_r[i] <= '0;
      end
    end else if (emit) begin
      loads_r[best_idx_r] <= new_load;
    end
  end

  // Output register; holds while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= frlb_pkg::OUT_TDATA_W'({head.length,
                                            frlb_pkg::IDX_FIELD_W'(best_idx_r)});
      out_last_r <= head.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/frlb_checker.sv =====
// Port-level checks for the least-loaded FASTA record binner.
// Depends on frlb_pkg; bound to fasta_record_least_loaded_binner below.
`default_nettype none

module frlb_checker (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tready,
  input  wire logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic [frlb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  wire logic                              out_tlast,
  input  wire logic                              cfg_valid,
  input  wire logic                              cfg_ready,
  input  wire logic [frlb_pkg::CFG_W-1:0]        cfg_data
);

  logic [frlb_pkg::CFG_W-1:0] bins_r;

  // Shadow of the bin count as written on the port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bins_r <= frlb_pkg::CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      bins_r <= cfg_data;
    end
  end

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  // Reset leaves no result pending and room for input.
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

  // With a single bin in use every record lands in bin zero.
  a_single_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (bins_r <= frlb_pkg::CFG_W'(1)) |-> out_tdata[3:0] == 4'd0)
    else $error("record placed outside the only bin");

  // Padding bits above the length stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[39:36] == 4'd0)
    else $error("result padding not zero");

endmodule

bind fasta_record_least_loaded_binner frlb_checker u_frlb_checker (.*);

`default_nettype wire

// ===== verif/fasta_record_least_loaded_binner_tb.sv =====
// Self-checking testbench for the least-loaded FASTA record binner.
// A directed table and then random FASTA-like text, with each result word
// checked against the table's own results or a predictor held in this file. Depends on frlb_pkg.
`default_nettype none

module fasta_record_least_loaded_binner_tb;

  // Block geometry and byte codes, taken from the package.
  localparam int MAX_BINS    = frlb_pkg::MAX_BINS;
  localparam int LOAD_W      = frlb_pkg::LOAD_W;
  localparam int LEN_W       = frlb_pkg::LEN_W;
  localparam int IDX_FIELD_W = frlb_pkg::IDX_FIELD_W;
  localparam int DATA_W      = frlb_pkg::DATA_W;
  localparam int CFG_W       = frlb_pkg::CFG_W;
  localparam int OUT_TDATA_W = frlb_pkg::OUT_TDATA_W;
  localparam logic [LOAD_W-1:0] LOAD_MAX   = frlb_pkg::LOAD_MAX;
  localparam logic [DATA_W-1:0] BYTE_LF    = frlb_pkg::BYTE_LF;
  localparam logic [DATA_W-1:0] BYTE_GT    = frlb_pkg::BYTE_GT;
  localparam logic [DATA_W-1:0] BYTE_SPACE = frlb_pkg::BYTE_SPACE;

  localparam int ITEM_TARGET = 1850;
  localparam int PHASES      = 8;
  localparam int SETTLE      = 2 * MAX_BINS + 8;
  localparam int HOLD_CYCLES = 600;
  localparam int CYCLE_LIMIT = 600000;
  localparam int N_DIRECTED  = 25;

  // One placement of a closed record, as the result word carries it.
  typedef struct packed {
    logic [IDX_FIELD_W-1:0] bin;
    logic [LEN_W-1:0]       length;
    logic                   last;
  } placement_t;

  // One row of the directed table; typed rows carry their own results.
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              fin;
    logic              typed;
    logic [1:0]        n_res;
    logic [LEN_W-1:0]  len_a;
    logic [LEN_W-1:0]  len_b;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata   = '0;   // data_byte
  logic                   in_tlast   = 1'b0; // final_byte
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;         // bin_index, record_length, zero pad
  logic                   out_tlast;         // last_result
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data   = '0;   // bin_count

  // Predictor state: bin loads, the open record, the current line.
  logic [LOAD_W-1:0] load_tab [MAX_BINS];
  logic              rec_open    = 1'b0;
  logic [LEN_W-1:0]  rec_len     = '0;
  logic              ln_marker   = 1'b0;
  logic              ln_nonempty = 1'b0;
  logic [LEN_W-1:0]  ln_count    = '0;
  logic [CFG_W-1:0]  bins_cfg    = 5'd1;

  // Placements made by the byte just accounted for.
  placement_t step_res [2];
  int         step_n = 0;

  placement_t placement_q[$];
  int         errors       = 0;
  int         bytes_sent   = 0;
  int         burst_left   = 0;
  int         cycles       = 0;
  bit         hold_req     = 1'b0;
  bit         hold_done    = 1'b0;

  // Directed table, walked after reset with one bin in use.
  stim_row_t directed_tab [N_DIRECTED] = '{
    '{BYTE_LF,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},  // empty line, nothing open
    '{BYTE_GT,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{8'hFF,      1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_LF,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},  // header opens a record
    '{8'h00,      1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_SPACE, 1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{8'h0D,      1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_LF,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},  // spaces do not count
    '{BYTE_SPACE, 1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_LF,    1'b0, 1'b0, 2'd0, 32'd0, 32'd0},  // line of spaces only
    '{BYTE_LF,    1'b0, 1'b1, 2'd1, 32'd2, 32'd0},  // empty line closes
    '{BYTE_GT,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_LF,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_GT,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_LF,    1'b0, 1'b1, 2'd1, 32'd0, 32'd0},  // header closes an empty record
    '{8'h41,      1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_LF,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_GT,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{8'h42,      1'b1, 1'b1, 2'd2, 32'd1, 32'd0},  // final byte on a header line
    '{8'h43,      1'b1, 1'b1, 2'd0, 32'd0, 32'd0},  // final byte, nothing open
    '{8'h7F,      1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_GT,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},  // marker in mid-line
    '{BYTE_LF,    1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{8'h80,      1'b0, 1'b1, 2'd0, 32'd0, 32'd0},
    '{BYTE_LF,    1'b1, 1'b1, 2'd1, 32'd1, 32'd0}   // final byte is a line end
  };

  // Bin counts per phase but the last two, which are random; extremes and out-of-range first.
  logic [CFG_W-1:0] cfg_plan [PHASES] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd17, 5'd3, 5'd8, 5'd2};

  fasta_record_least_loaded_binner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] a,
                                               input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? '1 : s[LEN_W-1:0];
  endfunction

  // Greedy placement: the least loaded bin in use, lowest index on ties.
  function automatic void close_open_record();
    int             used;
    int             best;
    logic [LOAD_W:0] sum;
    used = (bins_cfg == 0) ? 1 : ((bins_cfg > MAX_BINS) ? MAX_BINS : int'(bins_cfg));
    best = 0;
    for (int i = 1; i < used; i++) begin
      if (load_tab[i] < load_tab[best]) best = i;
    end
    sum = {1'b0, load_tab[best]} + {{(LOAD_W - LEN_W + 1){1'b0}}, rec_len};
    load_tab[best] = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
    step_res[step_n] = '{bin: best[IDX_FIELD_W-1:0], length: rec_len, last: 1'b0};
    step_n++;
    rec_open = 1'b0;
    rec_len  = '0;
  endfunction

  function automatic void finish_line();
    if (ln_marker) begin
      if (rec_open) close_open_record();
      rec_open = 1'b1;
      rec_len  = '0;
    end else if (!ln_nonempty) begin
      if (rec_open) close_open_record();
    end else if (rec_open) begin
      rec_len = sat_len(rec_len, ln_count);
    end
    ln_marker   = 1'b0;
    ln_nonempty = 1'b0;
    ln_count    = '0;
  endfunction

  // Works out the placements caused by one accepted byte.
  function automatic void account_byte(input logic [DATA_W-1:0] b, input logic fin);
    step_n = 0;
    if (b == BYTE_LF) begin
      finish_line();
    end else begin
      ln_nonempty = 1'b1;
      if (b == BYTE_GT) ln_marker = 1'b1;
      if (b != BYTE_SPACE) ln_count = sat_len(ln_count, LEN_W'(1));
    end
    if (fin) begin
      if (ln_nonempty) finish_line();
      if (rec_open) close_open_record();
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  // Offers one word; the sender runs in bursts with random gaps between.
  task automatic send_word(input logic [DATA_W-1:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic feed_byte(input logic [DATA_W-1:0] b, input logic fin);
    send_word(b, fin);
    account_byte(b, fin);
    for (int i = 0; i < step_n; i++) placement_q.push_back(step_res[i]);
  endtask

  // Waits until every placement has been seen and the block has gone quiet.
  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (placement_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_bin_count(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    bins_cfg = v;
  endtask

  function automatic logic [DATA_W-1:0] any_text_byte();
    logic [DATA_W-1:0] b;
    b = DATA_W'($urandom_range(0, 255));
    return (b == BYTE_LF) ? 8'h61 : b;
  endfunction

  // Mostly bases, with spaces, carriage returns and stray bytes mixed in.
  function automatic logic [DATA_W-1:0] seq_byte();
    logic [DATA_W-1:0] b;
    case ($urandom_range(0, 15))
      0, 1, 2:  b = 8'h41;
      3, 4, 5:  b = 8'h43;
      6, 7:     b = 8'h47;
      8, 9:     b = 8'h54;
      10:       b = BYTE_SPACE;
      11:       b = 8'h0D;
      12:       b = 8'h4E;
      default: begin
        b = any_text_byte();
        if (b == BYTE_GT) b = 8'h67;
      end
    endcase
    return b;
  endfunction

  // A header line and a few sequence lines; sometimes the end of the file.
  task automatic send_fasta_record();
    logic [DATA_W-1:0] rec_q[$];
    bit                end_file;
    int                n;
    end_file = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) rec_q.push_back(any_text_byte());
    end
    rec_q.push_back(BYTE_GT);
    n = $urandom_range(0, 6);
    repeat (n) rec_q.push_back(any_text_byte());
    rec_q.push_back(BYTE_LF);
    repeat ($urandom_range(0, 3)) begin
      n = $urandom_range(0, 14);
      repeat (n) rec_q.push_back(seq_byte());
      rec_q.push_back(BYTE_LF);
    end
    if ($urandom_range(0, 2) == 0) rec_q.push_back(BYTE_LF);
    // An unterminated last line at the end of the file.
    if (end_file && $urandom_range(0, 1) == 1 && rec_q.size() > 1 &&
        rec_q[rec_q.size()-2] != BYTE_LF)
      void'(rec_q.pop_back());
    for (int i = 0; i < rec_q.size(); i++)
      feed_byte(rec_q[i], end_file && (i == rec_q.size() - 1));
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 10);
    repeat (n) feed_byte(DATA_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
  endtask

  // Receiver: segments of steady, random and periodic stalls, and one long hold.
  initial begin : receiver
    int mode;
    int seg;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      seg  = (mode == 3) ? $urandom_range(1, 8) : $urandom_range(4, 40);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom_range(0, 1));
          2:       out_tready <= (k % 3) != 2;
          default: out_tready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  // Result checking against the oldest waiting placement.
  always @(posedge clk) begin : check_results
    placement_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (placement_q.size() == 0) begin
        $error("result word with none expected: tdata %h tlast %b", out_tdata, out_tlast);
        errors++;
      end else begin
        want = placement_q.pop_front();
        if (out_tdata[IDX_FIELD_W-1:0] !== want.bin) begin
          $error("bin_index: expected %0d, got %0d", want.bin, out_tdata[IDX_FIELD_W-1:0]);
          errors++;
        end
        if (out_tdata[IDX_FIELD_W +: LEN_W] !== want.length) begin
          $error("record_length: expected %0d, got %0d", want.length,
                 out_tdata[IDX_FIELD_W +: LEN_W]);
          errors++;
        end
        if (out_tdata[OUT_TDATA_W-1:IDX_FIELD_W+LEN_W] !== '0) begin
          $error("tdata pad: expected 0, got %h", out_tdata[OUT_TDATA_W-1:IDX_FIELD_W+LEN_W]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $error("last_result: expected %b, got %b", want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, then random phases of bin counts.
  initial begin : stimulus
    int quota;
    int phase_start;
    for (int i = 0; i < MAX_BINS; i++) load_tab[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      send_word(directed_tab[r].data, directed_tab[r].fin);
      account_byte(directed_tab[r].data, directed_tab[r].fin);
      if (directed_tab[r].typed) begin
        // One bin is in use after reset, so every record lands in bin 0.
        if (directed_tab[r].n_res == 2'd1) begin
          placement_q.push_back(placement_t'{bin: '0, length: directed_tab[r].len_a,
                                             last: 1'b1});
        end else if (directed_tab[r].n_res == 2'd2) begin
          placement_q.push_back(placement_t'{bin: '0, length: directed_tab[r].len_a,
                                             last: 1'b0});
          placement_q.push_back(placement_t'{bin: '0, length: directed_tab[r].len_b,
                                             last: 1'b1});
        end
      end else begin
        for (int i = 0; i < step_n; i++) placement_q.push_back(step_res[i]);
      end
    end

    quota = ITEM_TARGET / PHASES;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      write_bin_count((ph < PHASES - 2) ? cfg_plan[ph] : CFG_W'($urandom_range(0, 31)));
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < quota) begin
        if (ph == 1 && bytes_sent - phase_start > 30) hold_req = 1'b1;
        if ($urandom_range(0, 5) == 0) send_noise();
        else send_fasta_record();
      end
    end

    wait_drained();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/frlb_pkg.sv
rtl/frlb_front.sv
rtl/frlb_queue.sv
rtl/frlb_back.sv
rtl/fasta_record_least_loaded_binner.sv
rtl/frlb_checker.sv
verif/fasta_record_least_loaded_binner_tb.sv
